/* sv/segscan_pkg.sv */
// Shared types, constants and the segment code table of the three-digit
// seven-segment scanner. No dependencies.
`default_nettype none

package segscan_pkg;

   // Operation codes of the request channel
   typedef enum logic [1:0] {
      OP_SHOW_INT = 2'd0,
      OP_SHOW_DEC = 2'd1,
      OP_TICK     = 2'd2
   } op_type;

   // Register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_DIGIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_ROUNDS     = 2'd1;

   localparam logic [7:0] TICKS_RESET  = 8'd4;
   localparam logic [7:0] ROUNDS_RESET = 8'd50;

   localparam logic [13:0] INT_MAX = 14'd999;
   localparam logic [13:0] DEC_MAX = 14'd9999;
   localparam logic [13:0] DEC_TENS_MIN = 14'd1000;

   // Reciprocal multipliers, exact for every value up to 9999
   localparam logic [15:0] DIV10_MUL   = 16'd52429; // >> 19
   localparam logic [12:0] DIV100_MUL  = 13'd5243;  // >> 19
   localparam logic [14:0] DIV1000_MUL = 15'd16778; // >> 24

   // Segment codes, bit0 = a .. bit6 = g
   localparam logic [6:0] SEG_0 = 7'b0111111;
   localparam logic [6:0] SEG_1 = 7'b0000110;
   localparam logic [6:0] SEG_2 = 7'b1011011;
   localparam logic [6:0] SEG_3 = 7'b1001111;
   localparam logic [6:0] SEG_4 = 7'b1100110;
   localparam logic [6:0] SEG_5 = 7'b1101101;
   localparam logic [6:0] SEG_6 = 7'b1111101;
   localparam logic [6:0] SEG_7 = 7'b0000111;
   localparam logic [6:0] SEG_8 = 7'b1111111;
   localparam logic [6:0] SEG_9 = 7'b1101111;

   localparam logic [1:0] POINT_NONE  = 2'd0;
   localparam logic [1:0] POINT_FIRST = 2'd1;
   localparam logic [1:0] POINT_MID   = 2'd2;

   localparam logic [1:0] SLOT_LAST = 2'd2;

   typedef struct packed {
      logic [7:0] ticks_per_digit;
      logic [7:0] scan_rounds;
   } cfg_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] digit0;
      logic [3:0] digit1;
      logic [3:0] digit2;
      logic [1:0] point;
   } split_type;

   typedef struct packed {
      logic [6:0] segments;
      logic       decimal_point;
      logic [2:0] digit_select;
      logic       busy_res;
   } drive_type;

   // Codes above nine wrap around to their value modulo ten
   function automatic logic [6:0] seg_code(input logic [3:0] digit);
      logic [6:0] code;
      case (digit)
         4'd0, 4'd10: code = SEG_0;
         4'd1, 4'd11: code = SEG_1;
         4'd2, 4'd12: code = SEG_2;
         4'd3, 4'd13: code = SEG_3;
         4'd4, 4'd14: code = SEG_4;
         4'd5, 4'd15: code = SEG_5;
         4'd6:        code = SEG_6;
         4'd7:        code = SEG_7;
         4'd8:        code = SEG_8;
         4'd9:        code = SEG_9;
         default:     code = SEG_0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* sv/segscan_if.sv */
// Valid/ready channels of the scanner: request beats and result beats.
// Depends on nothing.
`default_nettype none

interface segscan_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [14:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface segscan_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] segments;
   logic       decimal_point;
   logic [2:0] digit_select;
   logic       busy_res;

   modport source (output valid, output segments, output decimal_point,
                   output digit_select, output busy_res, input ready);
   modport sink   (input valid, input segments, input decimal_point,
                   input digit_select, input busy_res, output ready);
endinterface

`default_nettype wire

/* sv/seven_segment_three_digit_scanner_core.sv */
// Top level of the three-digit seven-segment scanner: request register,
// result register and configuration registers. Depends on segscan_pkg,
// segscan_if, segscan_digit_split and segscan_scan_ctrl.
`default_nettype none

// The block takes one beat per clock unless the result port applies
// back-pressure: a request beat lands in the request register, and once the
// result register can advance, the digit split and the scan counters act on
// it and its result enters the result register.
// The scan state is updated in that same cycle,
// which lets each beat see the state left by the one before it. A show
// command (operation 0 integer 0..999, 1 hundredths 0..9999) blanks that
// result and reports whether a scan started; tick beats (operation 2) return
// the digit drive for that tick and advance the scan. Both registers hold
// under back-pressure. ticks_per_digit and scan_rounds must be written through
// the csr port while no beat is in flight; the block does not enforce this.
module seven_segment_three_digit_scanner_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   segscan_req_if.sink                              req_bus,
   segscan_rsp_if.source                            rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [segscan_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                          csr_wdata
);

   logic               req_valid_ff, req_valid_in;
   logic [1:0]         req_op_ff;
   logic signed [14:0] req_value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   segscan_pkg::drive_type rsp_data_ff;
   segscan_pkg::cfg_type   cfg_ff, cfg_in;

   logic                   advance;
   logic                   fire;
   logic                   req_take;
   segscan_pkg::split_type split;
   segscan_pkg::drive_type result;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = req_valid_ff && advance;
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign req_valid_in  = req_bus.ready ? req_bus.valid : req_valid_ff;
   assign rsp_valid_in  = advance ? req_valid_ff : rsp_valid_ff;

   segscan_digit_split u_split (
      .operation (req_op_ff),
      .value     (req_value_ff),
      .split     (split)
   );

   segscan_scan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .operation (req_op_ff),
      .split     (split),
      .cfg       (cfg_ff),
      .result    (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            segscan_pkg::CSR_TICKS_PER_DIGIT: cfg_in.ticks_per_digit = csr_wdata;
            segscan_pkg::CSR_SCAN_ROUNDS:     cfg_in.scan_rounds     = csr_wdata;
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.ticks_per_digit <= segscan_pkg::TICKS_RESET;
         cfg_ff.scan_rounds     <= segscan_pkg::ROUNDS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers: load on a taken or processed beat, otherwise hold
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_op_ff    <= req_bus.operation;
         req_value_ff <= req_bus.value;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.segments      = rsp_data_ff.segments;
   assign rsp_bus.decimal_point = rsp_data_ff.decimal_point;
   assign rsp_bus.digit_select  = rsp_data_ff.digit_select;
   assign rsp_bus.busy_res      = rsp_data_ff.busy_res;

`ifndef SYNTH
   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_data_ff.digit_select))
      else $error("more than one digit selected");

   a_select_needs_busy: assert property (@(posedge clock) disable iff (reset)
      fire && result.digit_select != 3'd0 |=> rsp_data_ff.busy_res)
      else $error("digit driven while no scan runs");

   a_fire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed beat produced no result");
`endif

endmodule

`default_nettype wire

/* sv/segscan_digit_split.sv */
// Range check and decimal digit split of a show command value.
// Depends on segscan_pkg.
`default_nettype none

module segscan_digit_split (
   input  wire logic [1:0]            operation,
   input  wire logic signed [14:0]    value,
   output segscan_pkg::split_type     split
);

   logic [13:0] mag;
   logic [29:0] prod10;
   logic [26:0] prod100;
   logic [28:0] prod1000;
   logic [9:0]  q10;
   logic [6:0]  q100;
   logic [3:0]  q1000;
   logic [13:0] rem10;
   logic [9:0]  rem100;
   logic [6:0]  rem1000;
   logic        is_int;

   assign mag    = value[13:0];
   assign is_int = (operation == segscan_pkg::OP_SHOW_INT);

   // Three independent quotients, each one constant multiply
   assign prod10   = {16'd0, mag} * {14'd0, segscan_pkg::DIV10_MUL};
   assign prod100  = {13'd0, mag} * {14'd0, segscan_pkg::DIV100_MUL};
   assign prod1000 = {15'd0, mag} * {14'd0, segscan_pkg::DIV1000_MUL};

   assign q10   = prod10[28:19];
   assign q100  = prod100[25:19];
   assign q1000 = prod1000[27:24];

   // Digit = quotient minus ten times the next quotient
   assign rem10   = mag - ({1'b0, q10, 3'd0} + {3'd0, q10, 1'b0});
   assign rem100  = q10 - ({q100, 3'd0} + {2'd0, q100, 1'b0});
   assign rem1000 = q100 - ({q1000, 3'd0} + {2'd0, q1000, 1'b0});

   always_comb begin
      split = '0;
      if (is_int) begin
         split.ok    = !value[14] && (mag <= segscan_pkg::INT_MAX);
         split.point = segscan_pkg::POINT_NONE;
      end else begin
         split.ok    = !value[14] && (mag <= segscan_pkg::DEC_MAX);
         split.point = segscan_pkg::POINT_FIRST;
      end
      if (!is_int && (mag >= segscan_pkg::DEC_TENS_MIN)) begin
         split.digit0 = q1000;
         split.digit1 = rem1000[3:0];
         split.digit2 = rem100[3:0];
         split.point  = segscan_pkg::POINT_MID;
      end else begin
         split.digit0 = rem1000[3:0];
         split.digit1 = rem100[3:0];
         split.digit2 = rem10[3:0];
      end
   end

endmodule

`default_nettype wire

/* sv/segscan_scan_ctrl.sv */
// Digit store, scan counters and segment drive of the scanner.
// Depends on segscan_pkg.
`default_nettype none

module segscan_scan_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [1:0]            operation,
   input  wire segscan_pkg::split_type split,
   input  wire segscan_pkg::cfg_type  cfg,
   output segscan_pkg::drive_type     result
);

   logic [3:0] digit0_ff, digit0_in;
   logic [3:0] digit1_ff, digit1_in;
   logic [3:0] digit2_ff, digit2_in;
   logic [1:0] point_ff, point_in;
   logic [1:0] slot_ff, slot_in;
   logic [7:0] tick_ff, tick_in;
   logic [7:0] round_ff, round_in;
   logic       showing_ff, showing_in;

   logic [7:0] limit;
   logic [7:0] tick_inc;
   logic [7:0] round_inc;
   logic [3:0] cur_digit;
   logic       is_show;
   segscan_pkg::drive_type drive_now;

   assign limit     = (cfg.ticks_per_digit == 8'd0) ? 8'd1 : cfg.ticks_per_digit;
   assign tick_inc  = tick_ff + 8'd1;
   assign round_inc = round_ff + 8'd1;
   assign is_show   = (operation == segscan_pkg::OP_SHOW_INT) ||
                      (operation == segscan_pkg::OP_SHOW_DEC);

   always_comb begin
      case (slot_ff)
         2'd0:    cur_digit = digit0_ff;
         2'd1:    cur_digit = digit1_ff;
         default: cur_digit = digit2_ff;
      endcase
   end

   always_comb begin
      drive_now = '0;
      if (showing_ff) begin
         drive_now.segments      = segscan_pkg::seg_code(cur_digit);
         drive_now.decimal_point = (point_ff == (slot_ff + 2'd1));
         drive_now.digit_select  = 3'd1 << slot_ff;
         drive_now.busy_res      = 1'b1;
      end
   end

   always_comb begin
      digit0_in  = digit0_ff;
      digit1_in  = digit1_ff;
      digit2_in  = digit2_ff;
      point_in   = point_ff;
      slot_in    = slot_ff;
      tick_in    = tick_ff;
      round_in   = round_ff;
      showing_in = showing_ff;
      result     = drive_now;
      if (fire) begin
         case (operation)
            segscan_pkg::OP_SHOW_INT, segscan_pkg::OP_SHOW_DEC: begin
               slot_in         = '0;
               tick_in         = '0;
               round_in        = '0;
               showing_in      = split.ok;
               result          = '0;
               result.busy_res = split.ok;
               // A rejected value keeps the old digits
               if (split.ok) begin
                  digit0_in = split.digit0;
                  digit1_in = split.digit1;
                  digit2_in = split.digit2;
                  point_in  = split.point;
               end
            end
            segscan_pkg::OP_TICK: begin
               if (showing_ff) begin
                  tick_in = tick_inc;
                  if (tick_inc >= limit) begin
                     tick_in = '0;
                     if (slot_ff >= segscan_pkg::SLOT_LAST) begin
                        slot_in  = '0;
                        round_in = round_inc;
                        if ((cfg.scan_rounds != 8'd0) && (round_inc >= cfg.scan_rounds)) begin
                           showing_in = 1'b0;
                        end
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
               end
            end
            default: begin
               // Unused code: show the drive, change nothing
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit0_ff  <= '0;
         digit1_ff  <= '0;
         digit2_ff  <= '0;
         point_ff   <= segscan_pkg::POINT_NONE;
         slot_ff    <= '0;
         tick_ff    <= '0;
         round_ff   <= '0;
         showing_ff <= 1'b0;
      end else begin
         digit0_ff  <= digit0_in;
         digit1_ff  <= digit1_in;
         digit2_ff  <= digit2_in;
         point_ff   <= point_in;
         slot_ff    <= slot_in;
         tick_ff    <= tick_in;
         round_ff   <= round_in;
         showing_ff <= showing_in;
      end
   end

`ifndef SYNTH
   a_show_ok_starts: assert property (@(posedge clock) disable iff (reset)
      fire && is_show && split.ok |=>
         showing_ff && slot_ff == 2'd0 && tick_ff == 8'd0 && round_ff == 8'd0)
      else $error("accepted show did not start a fresh scan");

   a_show_bad_blanks: assert property (@(posedge clock) disable iff (reset)
      fire && is_show && !split.ok |=> !showing_ff)
      else $error("rejected show left the display scanning");

   a_slot_holds: assert property (@(posedge clock) disable iff (reset)
      fire && operation == segscan_pkg::OP_TICK && showing_ff && tick_inc < limit
         |=> slot_ff == $past(slot_ff))
      else $error("slot moved before its ticks were spent");

   a_no_self_start: assert property (@(posedge clock) disable iff (reset)
      !showing_ff && !(fire && is_show) |=> !showing_ff)
      else $error("scan started without a show command");
`endif

endmodule

`default_nettype wire
